FILE: hdl/cfpr_pkg.sv
// ----------------------------------------------------------------------------
// cfpr_pkg: shared types and constants of the framed packet receiver
// Parse phase and event codes, the result record and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpr_pkg;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_SYNC = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_CHK  = 3'd5;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_DATA    = 3'd1;
	localparam logic [2:0] EV_OK      = 3'd2;
	localparam logic [2:0] EV_CRC_ERR = 3'd3;
	localparam logic [2:0] EV_LEN_ERR = 3'd4;
	localparam logic [2:0] EV_SYNC    = 3'd5;

	localparam logic [7:0] SYNC1_CHAR  = 8'h24;
	localparam logic [7:0] SYNC2_CHAR  = 8'h41;
	localparam logic [7:0] MAGIC0_CHAR = 8'h41;
	localparam logic [7:0] MAGIC1_CHAR = 8'h47;
	localparam logic [7:0] MAGIC2_CHAR = 8'h48;
	localparam logic [7:0] INFO_CMD    = 8'h01;
	localparam logic [7:0] CRC_POLY    = 8'hD5;
	localparam logic [7:0] LEN_SAT     = 8'd127;

	localparam int         INFO_LEN    = 12;
	localparam logic [6:0] INFO_LEN_7  = 7'd12;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  frame_cmd;
		logic [6:0]  frame_len;
		logic [7:0]  data_byte;
		logic [5:0]  data_index;
		logic        info_ok;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [7:0]  grid_rows;
		logic [7:0]  grid_cols;
		logic [15:0] pixel_width;
		logic [15:0] pixel_height;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/cfpr_parser.sv
// ----------------------------------------------------------------------------
// cfpr_parser: frame parse state and per-byte result logic
// Holds phase, command, length, count, CRC and the first payload bytes;
// forms the result of the byte in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_parser #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        byte_s1,
	output cfpr_pkg::result_t      res
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	logic [2:0] phase_q;
	logic [7:0] cmd_q;
	logic [7:0] crc_q;
	logic [6:0] len_q;
	logic [6:0] count_q;
	logic [7:0] info_q [cfpr_pkg::INFO_LEN];

	logic [2:0] phase_d;
	logic [7:0] cmd_d;
	logic [7:0] crc_d;
	logic [6:0] len_d;
	logic [6:0] count_d;
	logic       info_we;
	logic [7:0] crc_next;
	logic [6:0] count_inc;
	logic       info_match;

	assign crc_next  = cfpr_pkg::crc8_byte(crc_q, byte_s1);
	assign count_inc = count_q + 7'd1;
	assign info_we   = (phase_q == cfpr_pkg::PH_DATA) && (count_q < cfpr_pkg::INFO_LEN_7);
	assign info_match = (cmd_q == cfpr_pkg::INFO_CMD) && (len_q >= cfpr_pkg::INFO_LEN_7)
		&& (info_q[0] == cfpr_pkg::MAGIC0_CHAR) && (info_q[1] == cfpr_pkg::MAGIC1_CHAR)
		&& (info_q[2] == cfpr_pkg::MAGIC2_CHAR);

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		crc_d   = crc_q;
		len_d   = len_q;
		count_d = count_q;
		res     = '0;
		res.frame_cmd = cmd_q;
		res.frame_len = len_q;
		case (phase_q)
			cfpr_pkg::PH_SYNC: begin
				if (byte_s1 != cfpr_pkg::SYNC2_CHAR) begin
					phase_d = cfpr_pkg::PH_HUNT;
					cmd_d   = '0;
					crc_d   = '0;
					len_d   = '0;
					count_d = '0;
					res.event_res = cfpr_pkg::EV_SYNC;
				end else begin
					phase_d = cfpr_pkg::PH_CMD;
				end
			end
			cfpr_pkg::PH_CMD: begin
				crc_d   = crc_next;
				cmd_d   = byte_s1;
				res.frame_cmd = byte_s1;
				phase_d = cfpr_pkg::PH_LEN;
			end
			cfpr_pkg::PH_LEN: begin
				if (byte_s1 > MaxLen) begin
					res.frame_len = (byte_s1 > cfpr_pkg::LEN_SAT) ? 7'd127 : byte_s1[6:0];
					phase_d = cfpr_pkg::PH_HUNT;
					cmd_d   = '0;
					crc_d   = '0;
					len_d   = '0;
					count_d = '0;
					res.event_res = cfpr_pkg::EV_LEN_ERR;
				end else begin
					crc_d   = crc_next;
					len_d   = byte_s1[6:0];
					count_d = '0;
					res.frame_len = byte_s1[6:0];
					phase_d = (byte_s1 != 8'd0) ? cfpr_pkg::PH_DATA : cfpr_pkg::PH_CHK;
				end
			end
			cfpr_pkg::PH_DATA: begin
				crc_d   = crc_next;
				count_d = count_inc;
				res.event_res  = cfpr_pkg::EV_DATA;
				res.data_byte  = byte_s1;
				res.data_index = count_q[5:0];
				if (count_inc >= len_q) begin
					phase_d = cfpr_pkg::PH_CHK;
				end
			end
			cfpr_pkg::PH_CHK: begin
				if (byte_s1 != crc_q) begin
					res.event_res = cfpr_pkg::EV_CRC_ERR;
				end else begin
					res.event_res = cfpr_pkg::EV_OK;
					if (info_match) begin
						res.info_ok       = 1'b1;
						res.version_major = info_q[3];
						res.version_minor = info_q[4];
						res.grid_rows     = info_q[6];
						res.grid_cols     = info_q[7];
						res.pixel_width   = {info_q[9], info_q[8]};
						res.pixel_height  = {info_q[11], info_q[10]};
					end
				end
				phase_d = cfpr_pkg::PH_HUNT;
				cmd_d   = '0;
				crc_d   = '0;
				len_d   = '0;
				count_d = '0;
			end
			default: begin
				phase_d = (byte_s1 == cfpr_pkg::SYNC1_CHAR) ? cfpr_pkg::PH_SYNC
					: cfpr_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfpr_pkg::PH_HUNT;
			cmd_q   <= '0;
			crc_q   <= '0;
			len_q   <= '0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			crc_q   <= crc_d;
			len_q   <= len_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && info_we) begin
			info_q[count_q[3:0]] <= byte_s1;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/crc8_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver: framed packet receiver with CRC-8 check
// Input register, frame parser and result register; one result per byte.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  input   | in_valid, in_stall, rx_byte      | byte in
//  output  | out_valid, out_stall, result set | one result per byte out
//
//  One byte transfer per cycle while in_stall is low; a byte's result is registered after its parser step.
//  The rate is set by the combinational parser step between the two registers.
//  Reset returns the parser to preamble hunt and empties both registers.
//  A stalled output holds; the input register still takes one more byte if it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_framed_packet_receiver #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_res,
	output logic [7:0]       frame_cmd,
	output logic [6:0]       frame_len,
	output logic [7:0]       data_byte,
	output logic [5:0]       data_index,
	output logic             info_ok,
	output logic [7:0]       version_major,
	output logic [7:0]       version_minor,
	output logic [7:0]       grid_rows,
	output logic [7:0]       grid_cols,
	output logic [15:0]      pixel_width,
	output logic [15:0]      pixel_height
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	cfpr_pkg::result_t res_q;
	cfpr_pkg::result_t res;
	logic              advance;
	logic              load_s1;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	cfpr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= rx_byte;
		end
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = res_q.event_res;
	assign frame_cmd     = res_q.frame_cmd;
	assign frame_len     = res_q.frame_len;
	assign data_byte     = res_q.data_byte;
	assign data_index    = res_q.data_index;
	assign info_ok       = res_q.info_ok;
	assign version_major = res_q.version_major;
	assign version_minor = res_q.version_minor;
	assign grid_rows     = res_q.grid_rows;
	assign grid_cols     = res_q.grid_cols;
	assign pixel_width   = res_q.pixel_width;
	assign pixel_height  = res_q.pixel_height;

endmodule

`default_nettype wire
